### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out under synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

### rtl/lrukv_pkg.sv
// ---------------------------------------------------------------------------
// lrukv_pkg
// shared types and constants of the lru key-value cache
// ---------------------------------------------------------------------------
package lrukv_pkg;
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 32;
	localparam int IDX_BITS   = $clog2(ENTRIES);
	localparam int AGE_BITS   = $clog2(ENTRIES);
	localparam int OCC_BITS   = 5;
	localparam int CAP_BITS   = 5;

	typedef logic [2:0] op_t;
	localparam op_t OP_PUT      = 3'd0;
	localparam op_t OP_GET      = 3'd1;
	localparam op_t OP_REMOVE   = 3'd2;
	localparam op_t OP_CONTAINS = 3'd3;
	localparam op_t OP_CLEAR    = 3'd4;
	localparam op_t OP_RSTAT    = 3'd5;

	typedef struct packed {
		op_t                   operation;
		logic [KEY_BITS-1:0]   lookup_key;
		logic [VALUE_BITS-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic                  status;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [VALUE_BITS-1:0] evicted_value;
		logic [OCC_BITS-1:0]   live_count;
		logic [COUNT_BITS-1:0] hit_total;
		logic [COUNT_BITS-1:0] miss_total;
		logic [COUNT_BITS-1:0] put_total;
		logic [COUNT_BITS-1:0] eviction_total;
	} rsp_t;

	// classified command handed from front to back
	typedef struct packed {
		op_t                   operation;
		logic                  hit;
		logic [IDX_BITS-1:0]   slot;
		logic [KEY_BITS-1:0]   lookup_key;
		logic [VALUE_BITS-1:0] write_value;
	} cmd_t;
endpackage

### rtl/lrukv_req_if.sv
// ---------------------------------------------------------------------------
// lrukv_req_if
// valid/ready channel for request words
// ---------------------------------------------------------------------------
interface lrukv_req_if;
	logic              valid;
	logic              ready;
	lrukv_pkg::req_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/lrukv_rsp_if.sv
// ---------------------------------------------------------------------------
// lrukv_rsp_if
// valid/ready channel for response words
// ---------------------------------------------------------------------------
interface lrukv_rsp_if;
	logic              valid;
	logic              ready;
	lrukv_pkg::rsp_t   data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/lrukv_front.sv
// ---------------------------------------------------------------------------
// lrukv_front
// accepts a request word, compares its key against all live entries and
// hands a classified command to the back end
// ---------------------------------------------------------------------------
module lrukv_front (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          req_valid,
	output logic                                          req_ready,
	input  lrukv_pkg::req_t                               req_data,
	input  logic [lrukv_pkg::ENTRIES-1:0]                 entry_valid,
	input  logic [lrukv_pkg::ENTRIES-1:0][lrukv_pkg::KEY_BITS-1:0] entry_key,
	input  logic                                          busy,
	output logic                                          cmd_valid,
	input  logic                                          cmd_ready,
	output lrukv_pkg::cmd_t                               cmd_data
);
	logic                              hold_q;
	lrukv_pkg::req_t                   req_q;
	logic                              hit;
	logic [lrukv_pkg::IDX_BITS-1:0]    slot;

	// one item in flight: the tag compare reads state only when back end is idle
	assign req_ready = !hold_q && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (req_valid && req_ready) begin
			hold_q <= 1'b1;
		end else if (cmd_valid && cmd_ready) begin
			hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req_data;
		end
	end

	// parallel key match
	always_comb begin
		hit  = 1'b0;
		slot = '0;
		for (int i = lrukv_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (entry_valid[i] && entry_key[i] == req_q.lookup_key) begin
				hit  = 1'b1;
				slot = lrukv_pkg::IDX_BITS'(i);
			end
		end
	end

	assign cmd_valid            = hold_q;
	assign cmd_data.operation   = req_q.operation;
	assign cmd_data.hit         = hit;
	assign cmd_data.slot        = slot;
	assign cmd_data.lookup_key  = req_q.lookup_key;
	assign cmd_data.write_value = req_q.write_value;
endmodule

### rtl/lrukv_back.sv
// ---------------------------------------------------------------------------
// lrukv_back
// holds the entry table and counters, carries out a classified command and
// registers the response word
// ---------------------------------------------------------------------------
module lrukv_back (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [lrukv_pkg::CAP_BITS-1:0]                cfg_data,
	input  logic                                          cmd_valid,
	output logic                                          cmd_ready,
	input  lrukv_pkg::cmd_t                               cmd_data,
	output logic [lrukv_pkg::ENTRIES-1:0]                 entry_valid,
	output logic [lrukv_pkg::ENTRIES-1:0][lrukv_pkg::KEY_BITS-1:0] entry_key,
	output logic                                          busy,
	output logic                                          rsp_valid,
	input  logic                                          rsp_ready,
	output lrukv_pkg::rsp_t                               rsp_data
);
	localparam int E = lrukv_pkg::ENTRIES;
	localparam int AB = lrukv_pkg::AGE_BITS;
	localparam int VB = lrukv_pkg::VALUE_BITS;
	localparam int CB = lrukv_pkg::COUNT_BITS;

	logic [E-1:0]                         valid_q;
	logic [E-1:0][lrukv_pkg::KEY_BITS-1:0] key_q;
	logic [E-1:0][VB-1:0]                 value_q;
	logic [E-1:0][AB-1:0]                 age_q;
	logic [lrukv_pkg::OCC_BITS-1:0]       occ_q;
	logic [lrukv_pkg::CAP_BITS-1:0]       cap_q;
	logic [CB-1:0]                        hits_q, misses_q, puts_q, evicts_q;
	logic                                 rsp_valid_q;
	lrukv_pkg::rsp_t                      rsp_q;

	logic                                 take;
	logic [AB-1:0]                        slot_age;
	logic                                 full;
	logic                                 old_found;
	logic [lrukv_pkg::IDX_BITS-1:0]       old_slot;
	logic                                 free_found;
	logic [lrukv_pkg::IDX_BITS-1:0]       free_slot;
	logic [E-1:0]                         valid_after_evict;

	assign entry_valid = valid_q;
	assign entry_key   = key_q;
	assign take        = cmd_valid && cmd_ready;
	assign cmd_ready   = !rsp_valid_q;
	assign busy        = rsp_valid_q;
	assign rsp_valid   = rsp_valid_q;
	assign rsp_data    = rsp_q;

	assign slot_age = age_q[cmd_data.slot];
	assign full     = occ_q >= cap_q;

	// oldest entry and lowest free slot
	always_comb begin
		old_found = 1'b0;
		old_slot  = '0;
		for (int i = E - 1; i >= 0; i--) begin
			if (valid_q[i] && {1'b0, age_q[i]} == occ_q - 1'b1) begin
				old_found = 1'b1;
				old_slot  = lrukv_pkg::IDX_BITS'(i);
			end
		end
		valid_after_evict = valid_q;
		if (full && old_found) begin
			valid_after_evict[old_slot] = 1'b0;
		end
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = E - 1; i >= 0; i--) begin
			if (!valid_after_evict[i]) begin
				free_found = 1'b1;
				free_slot  = lrukv_pkg::IDX_BITS'(i);
			end
		end
	end

	// control state, table and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			key_q       <= '0;
			value_q     <= '0;
			age_q       <= '0;
			occ_q       <= '0;
			cap_q       <= lrukv_pkg::CAP_BITS'(E);
			hits_q      <= '0;
			misses_q    <= '0;
			puts_q      <= '0;
			evicts_q    <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (cfg_we && occ_q == '0) begin
				if (cfg_data == '0) begin
					cap_q <= lrukv_pkg::CAP_BITS'(1);
				end else if (cfg_data > lrukv_pkg::CAP_BITS'(E)) begin
					cap_q <= lrukv_pkg::CAP_BITS'(E);
				end else begin
					cap_q <= cfg_data;
				end
			end
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (take) begin
				rsp_valid_q <= 1'b1;
				rsp_q.status        <= 1'b0;
				rsp_q.read_value    <= '0;
				rsp_q.evicted       <= 1'b0;
				rsp_q.evicted_value <= '0;
				rsp_q.live_count    <= occ_q;
				rsp_q.hit_total     <= hits_q;
				rsp_q.miss_total    <= misses_q;
				rsp_q.put_total     <= puts_q;
				rsp_q.eviction_total <= evicts_q;
				case (cmd_data.operation)
					lrukv_pkg::OP_PUT: begin
						rsp_q.put_total <= puts_q + 1'b1;
						puts_q <= puts_q + 1'b1;
						if (cmd_data.hit) begin
							value_q[cmd_data.slot] <= cmd_data.write_value;
							for (int i = 0; i < E; i++) begin
								if (valid_q[i] && age_q[i] < slot_age) begin
									age_q[i] <= age_q[i] + 1'b1;
								end
							end
							age_q[cmd_data.slot] <= '0;
						end else begin
							if (full && old_found) begin
								rsp_q.evicted        <= 1'b1;
								rsp_q.evicted_value  <= value_q[old_slot];
								rsp_q.eviction_total <= evicts_q + 1'b1;
								evicts_q <= evicts_q + 1'b1;
							end
							// the evicted entry is the oldest, so all others just age
							for (int i = 0; i < E; i++) begin
								if (valid_after_evict[i]) begin
									age_q[i] <= age_q[i] + 1'b1;
								end
							end
							if (free_found) begin
								valid_q           <= valid_after_evict;
								valid_q[free_slot] <= 1'b1;
								key_q[free_slot]   <= cmd_data.lookup_key;
								value_q[free_slot] <= cmd_data.write_value;
								age_q[free_slot]   <= '0;
								if (!(full && old_found)) begin
									occ_q <= occ_q + 1'b1;
									rsp_q.live_count <= occ_q + 1'b1;
								end
							end else begin
								valid_q <= valid_after_evict;
								if (full && old_found) begin
									occ_q <= occ_q - 1'b1;
									rsp_q.live_count <= occ_q - 1'b1;
								end
							end
						end
					end
					lrukv_pkg::OP_GET: begin
						if (cmd_data.hit) begin
							rsp_q.read_value <= value_q[cmd_data.slot];
							rsp_q.hit_total  <= hits_q + 1'b1;
							hits_q <= hits_q + 1'b1;
							for (int i = 0; i < E; i++) begin
								if (valid_q[i] && age_q[i] < slot_age) begin
									age_q[i] <= age_q[i] + 1'b1;
								end
							end
							age_q[cmd_data.slot] <= '0;
						end else begin
							rsp_q.status     <= 1'b1;
							rsp_q.miss_total <= misses_q + 1'b1;
							misses_q <= misses_q + 1'b1;
						end
					end
					lrukv_pkg::OP_REMOVE: begin
						if (cmd_data.hit) begin
							valid_q[cmd_data.slot] <= 1'b0;
							for (int i = 0; i < E; i++) begin
								if (valid_q[i] && age_q[i] > slot_age) begin
									age_q[i] <= age_q[i] - 1'b1;
								end
							end
							occ_q <= occ_q - 1'b1;
							rsp_q.live_count <= occ_q - 1'b1;
						end else begin
							rsp_q.status <= 1'b1;
						end
					end
					lrukv_pkg::OP_CONTAINS: begin
						rsp_q.status <= !cmd_data.hit;
					end
					lrukv_pkg::OP_CLEAR: begin
						valid_q <= '0;
						occ_q   <= '0;
						evicts_q <= '0;
						rsp_q.live_count     <= '0;
						rsp_q.eviction_total <= '0;
					end
					lrukv_pkg::OP_RSTAT: begin
						hits_q   <= '0;
						misses_q <= '0;
						puts_q   <= '0;
						evicts_q <= '0;
						rsp_q.hit_total      <= '0;
						rsp_q.miss_total     <= '0;
						rsp_q.put_total      <= '0;
						rsp_q.eviction_total <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end
endmodule

### rtl/lru_key_value_cache_top.sv
// ---------------------------------------------------------------------------
// lru_key_value_cache_top
// fully associative lru key-value cache, front compare and back update
// ---------------------------------------------------------------------------
// channel    dir  handshake     word
// req        in   valid/ready   operation, lookup_key, write_value
// rsp        out  valid/ready   status .. eviction_total
// cfg        in   cfg_we        capacity_limit
//
// from its accept to its response word an item passes key compare in the front,
// then table update in the back; a new word is taken in the cycle after the
// response word leaves the output reg.
// reset clears valid bits, table and counters and sets capacity to 16.
// a stalled response holds the back end and through it the front.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module lru_key_value_cache_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lrukv_pkg::CAP_BITS-1:0]   cfg_data,
	lrukv_req_if.sink                        req,
	lrukv_rsp_if.source                      rsp
);
	logic                                                          cmd_valid;
	logic                                                          cmd_ready;
	lrukv_pkg::cmd_t                                               cmd_data;
	logic [lrukv_pkg::ENTRIES-1:0]                                 entry_valid;
	logic [lrukv_pkg::ENTRIES-1:0][lrukv_pkg::KEY_BITS-1:0]        entry_key;
	logic                                                          busy;

	// compare front
	lrukv_front u_front (
		.clk, .arst_n,
		.req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
		.entry_valid, .entry_key, .busy,
		.cmd_valid, .cmd_ready, .cmd_data
	);

	// update back
	lrukv_back u_back (
		.clk, .arst_n, .cfg_we, .cfg_data,
		.cmd_valid, .cmd_ready, .cmd_data,
		.entry_valid, .entry_key, .busy,
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
	);

	// checks
	`ASSERT_IMPL(a_cmd_to_rsp, clk, arst_n, (cmd_valid && cmd_ready) |=> rsp.valid, "no response")
	`ASSERT_NEVER(a_no_accept_busy, clk, arst_n, req.valid && req.ready && rsp.valid, "accept busy")
	`ASSERT_IMPL(a_live_bound, clk, arst_n, rsp.data.live_count <= lrukv_pkg::OCC_BITS'(lrukv_pkg::ENTRIES) || !rsp.valid, "count")
endmodule

### bench/tb_lru_key_value_cache_top.sv
// ---------------------------------------------------------------------------
// tb_lru_key_value_cache_top
// self-checking bench for the lru key-value cache: a directed table of
// words, then random traffic of all opcodes over a small key pool,
// each response word compared field by field with a predicted word
// ---------------------------------------------------------------------------
module tb_lru_key_value_cache_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lrukv_pkg::*;

	localparam op_t OP_NOP6 = 3'd6;
	localparam op_t OP_NOP7 = 3'd7;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CAP_BITS-1:0] cfg_data = '0;

	lrukv_req_if req ();
	lrukv_rsp_if rsp ();

	lru_key_value_cache_top dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req.sink), .rsp(rsp.source)
	);

	always #5 clk = ~clk;

	// predictor state
	logic                  slot_live [ENTRIES];
	logic [KEY_BITS-1:0]   slot_key  [ENTRIES];
	logic [VALUE_BITS-1:0] slot_val  [ENTRIES];
	int                    slot_rank [ENTRIES];
	int                    live_n;
	int                    cap;
	logic [COUNT_BITS-1:0] n_hit, n_miss, n_put, n_evict;

	rsp_t expected_words [$];
	int   fail_count = 0;
	int   idle_cycles = 0;
	bit   quiet = 0;
	bit   hold_off = 0;

	// directed table: word plus an optional typed-in expectation
	typedef struct {
		req_t word;
		bit   fixed;
		rsp_t want;
	} row_t;

	function automatic int find_key(logic [KEY_BITS-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void make_newest(int s);
		int a;
		a = slot_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_rank[i] < a) slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	function automatic void free_slot(int s);
		int a;
		a = slot_rank[s];
		slot_live[s] = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_rank[i] > a) slot_rank[i]--;
		if (live_n > 0) live_n--;
	endfunction

	function automatic void cache_reset();
		for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
		live_n = 0;
		cap = ENTRIES;
		n_hit = '0; n_miss = '0; n_put = '0; n_evict = '0;
	endfunction

	function automatic void capacity_write(logic [CAP_BITS-1:0] v);
		int c;
		if (live_n != 0) return;
		c = (v == 0) ? 1 : int'(v);
		cap = (c > ENTRIES) ? ENTRIES : c;
	endfunction

	// predicted response word for one request word
	function automatic rsp_t cache_access(req_t w);
		rsp_t r;
		int s, f;
		r = '0;
		case (w.operation)
			OP_PUT: begin
				s = find_key(w.lookup_key);
				if (s >= 0) begin
					slot_val[s] = w.write_value;
					make_newest(s);
				end else begin
					if (live_n >= cap)
						for (int i = 0; i < ENTRIES; i++)
							if (slot_live[i] && slot_rank[i] == live_n - 1) begin
								r.evicted = 1'b1;
								r.evicted_value = slot_val[i];
								free_slot(i);
								n_evict++;
								break;
							end
					f = -1;
					for (int i = ENTRIES - 1; i >= 0; i--)
						if (!slot_live[i]) f = i;
					if (f >= 0) begin
						for (int j = 0; j < ENTRIES; j++)
							if (slot_live[j]) slot_rank[j]++;
						slot_live[f] = 1'b1;
						slot_key[f] = w.lookup_key;
						slot_val[f] = w.write_value;
						slot_rank[f] = 0;
						live_n++;
					end
				end
				n_put++;
			end
			OP_GET: begin
				s = find_key(w.lookup_key);
				if (s >= 0) begin
					r.read_value = slot_val[s];
					make_newest(s);
					n_hit++;
				end else begin
					r.status = 1'b1;
					n_miss++;
				end
			end
			OP_REMOVE: begin
				s = find_key(w.lookup_key);
				if (s >= 0) free_slot(s);
				else r.status = 1'b1;
			end
			OP_CONTAINS: r.status = (find_key(w.lookup_key) < 0);
			OP_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++) slot_live[i] = 1'b0;
				live_n = 0;
				n_evict = '0;
			end
			OP_RSTAT: begin
				n_hit = '0; n_miss = '0; n_put = '0; n_evict = '0;
			end
			default: ;
		endcase
		r.live_count = live_n[OCC_BITS-1:0];
		r.hit_total = n_hit;
		r.miss_total = n_miss;
		r.put_total = n_put;
		r.eviction_total = n_evict;
		return r;
	endfunction

	function automatic req_t mk(op_t o, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		req_t w;
		w.operation = o; w.lookup_key = k; w.write_value = v;
		return w;
	endfunction

	function automatic rsp_t mk_rsp(logic st, logic [VALUE_BITS-1:0] rd, logic ev,
			logic [VALUE_BITS-1:0] evv, int live, int h, int m, int p, int e);
		rsp_t r;
		r.status = st; r.read_value = rd; r.evicted = ev; r.evicted_value = evv;
		r.live_count = live[OCC_BITS-1:0];
		r.hit_total = h; r.miss_total = m; r.put_total = p; r.eviction_total = e;
		return r;
	endfunction

	// response sink: random bursts of back-pressure, one long hold-off
	initial begin
		int n;
		rsp.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				rsp.ready <= 1'b0;
				repeat (40) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 5);
				rsp.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_t e, a;
		if (arst_n && rsp.valid && rsp.ready) begin
			a = rsp.data;
			if (expected_words.size() == 0) begin
				$error("response word with none expected");
				fail_count++;
			end else begin
				e = expected_words.pop_front();
				if (a.status !== e.status) begin
					$error("status exp %0h got %0h", e.status, a.status); fail_count++; end
				if (a.read_value !== e.read_value) begin
					$error("read_value exp %0h got %0h", e.read_value, a.read_value);
					fail_count++; end
				if (a.evicted !== e.evicted) begin
					$error("evicted exp %0h got %0h", e.evicted, a.evicted); fail_count++; end
				if (a.evicted_value !== e.evicted_value) begin
					$error("evicted_value exp %0h got %0h", e.evicted_value, a.evicted_value);
					fail_count++; end
				if (a.live_count !== e.live_count) begin
					$error("live_count exp %0d got %0d", e.live_count, a.live_count);
					fail_count++; end
				if (a.hit_total !== e.hit_total) begin
					$error("hit_total exp %0d got %0d", e.hit_total, a.hit_total);
					fail_count++; end
				if (a.miss_total !== e.miss_total) begin
					$error("miss_total exp %0d got %0d", e.miss_total, a.miss_total);
					fail_count++; end
				if (a.put_total !== e.put_total) begin
					$error("put_total exp %0d got %0d", e.put_total, a.put_total);
					fail_count++; end
				if (a.eviction_total !== e.eviction_total) begin
					$error("eviction_total exp %0d got %0d", e.eviction_total,
						a.eviction_total);
					fail_count++; end
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// send one word; the predictor runs when it is accepted
	// valid stays up into the next word unless a random gap drops it; drain drops it
	task automatic send_word(req_t w, bit fixed, rsp_t want);
		rsp_t p;
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 5);
			req.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= w;
		do @(posedge clk); while (!req.ready);
		p = cache_access(w);
		expected_words.push_back(fixed ? want : p);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_BITS-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		capacity_write(v);
	endtask

	function automatic logic [KEY_BITS-1:0] pick_key(int pool);
		if ($urandom_range(0, 19) == 0) return $urandom();
		return 32'h5A00_0000 ^ $urandom_range(0, pool - 1);
	endfunction

	initial begin
		row_t table_rows [$];
		req_t w;
		rsp_t none;
		int   caps [6];
		int   pool;
		none = '0;
		req.valid = 1'b0;
		req.data = '0;
		cache_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, fixed expectations where obvious
		table_rows.push_back('{mk(OP_GET, 32'h0, 32'h0), 1, mk_rsp(1, 0, 0, 0, 0, 0, 1, 0, 0)});
		table_rows.push_back('{mk(OP_CONTAINS, '1, 32'h0), 1, mk_rsp(1, 0, 0, 0, 0, 0, 1, 0, 0)});
		table_rows.push_back('{mk(OP_REMOVE, 32'h0, 32'h0), 1, mk_rsp(1, 0, 0, 0, 0, 0, 1, 0, 0)});
		table_rows.push_back('{mk(OP_PUT, 32'h0, '1), 1, mk_rsp(0, 0, 0, 0, 1, 0, 1, 1, 0)});
		table_rows.push_back('{mk(OP_PUT, '1, 32'h0), 1, mk_rsp(0, 0, 0, 0, 2, 0, 1, 2, 0)});
		table_rows.push_back('{mk(OP_GET, 32'h0, 32'h0), 1, mk_rsp(0, '1, 0, 0, 2, 1, 1, 2, 0)});
		table_rows.push_back('{mk(OP_PUT, 32'h0, 32'h1234_5678), 0, none});
		table_rows.push_back('{mk(OP_GET, 32'h0, 32'h0), 0, none});
		table_rows.push_back('{mk(OP_CONTAINS, '1, 32'h0), 0, none});
		table_rows.push_back('{mk(OP_NOP6, '1, '1), 0, none});
		table_rows.push_back('{mk(OP_NOP7, 32'h0, 32'h0), 0, none});
		table_rows.push_back('{mk(OP_REMOVE, '1, 32'h0), 0, none});
		table_rows.push_back('{mk(OP_RSTAT, 32'h0, 32'h0), 0, none});
		table_rows.push_back('{mk(OP_CLEAR, 32'h0, 32'h0), 1, mk_rsp(0, 0, 0, 0, 0, 0, 0, 0, 0)});
		foreach (table_rows[i]) send_word(table_rows[i].word, table_rows[i].fixed,
			table_rows[i].want);

		// capacity one and zero (treated as one), eviction on every new key
		set_capacity(5'd0);
		send_word(mk(OP_PUT, 32'hA, 32'hAAAA_0001), 0, none);
		send_word(mk(OP_PUT, 32'hB, 32'hBBBB_0002), 0, none);
		send_word(mk(OP_PUT, 32'hB, 32'hBBBB_0003), 0, none);
		// written while live: ignored
		set_capacity(5'd16);
		send_word(mk(OP_PUT, 32'hC, 32'hCCCC_0004), 0, none);
		send_word(mk(OP_CLEAR, 32'h0, 32'h0), 0, none);
		// above the entry count: saturates
		set_capacity(5'd31);

		// random phases across capacity settings
		caps = '{31, 1, 16, 3, 8, 16};
		foreach (caps[c]) begin
			if (c != 0) begin
				send_word(mk(OP_CLEAR, 32'h0, 32'h0), 0, none);
				set_capacity(caps[c][CAP_BITS-1:0]);
			end
			if (c == 2) hold_off = 1;
			if (c == 5) quiet = 1;
			pool = (caps[c] > 16 ? 16 : caps[c]) + $urandom_range(1, 6);
			for (int k = 0; k < 150; k++) begin
				w.lookup_key = pick_key(pool);
				w.write_value = $urandom();
				case ($urandom_range(0, 99)) inside
					[0:39]:  w.operation = OP_PUT;
					[40:69]: w.operation = OP_GET;
					[70:81]: w.operation = OP_REMOVE;
					[82:93]: w.operation = OP_CONTAINS;
					[94:95]: w.operation = OP_CLEAR;
					[96:97]: w.operation = OP_RSTAT;
					default: w.operation = op_t'($urandom_range(6, 7));
				endcase
				send_word(w, 0, none);
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
